FILE: rtl/core/lsd_pkg.sv
// lsd_pkg: shared types and constants for the lookahead sequence diff unit
// no dependencies; imported by lsd_ctrl, the top level and the bench
`default_nettype none

package lsd_pkg;

  localparam int WORD_WIDTH      = 32;
  localparam int POS_W           = 10;
  localparam int MAX_LEN_DEF     = 1024;
  localparam int LOOKAHEAD_DEF   = 32;
  localparam int SYNC_DEF        = 8;
  localparam int DEPTH_W         = 6;
  localparam int SYNC_W          = 4;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd32;
  localparam logic [SYNC_W-1:0]  SYNC_RESET  = 4'd3;

  typedef enum logic [1:0] {
    OP_CLEAR        = 2'd0,
    OP_APPEND_LEFT  = 2'd1,
    OP_APPEND_RIGHT = 2'd2,
    OP_STEP         = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_COMMON   = 3'd0,
    K_LEFT     = 3'd1,
    K_RIGHT    = 3'd2,
    K_DIFF     = 3'd3,
    K_FINISHED = 3'd4,
    K_OVERFLOW = 3'd5
  } kind_t;

  typedef enum logic {
    REG_LOOKAHEAD_DEPTH = 1'b0,
    REG_SYNC_LENGTH     = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SRCH_CHK,
    ST_SRCH_CMP,
    ST_RUN_RD,
    ST_RUN_EMIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                   opcode;
    logic [WORD_WIDTH-1:0] word;
  } in_item_t;

  typedef struct packed {
    kind_t                 kind;
    logic [WORD_WIDTH-1:0] left_word;
    logic [WORD_WIDTH-1:0] right_word;
    logic [POS_W-1:0]      left_position;
    logic [POS_W-1:0]      right_position;
    logic                  last;
  } out_item_t;

  typedef struct packed {
    logic [DEPTH_W-1:0] lookahead_depth;
    logic [SYNC_W-1:0]  sync_length;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/core/lsd_ram.sv
// lsd_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module lsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/lsd_ctrl.sv
// lsd_ctrl: request sequencer, counts, cursors, lookahead search and result register
// depends on lsd_pkg; drives the two lsd_ram instances in the top level
`default_nettype none

module lsd_ctrl #(
  parameter int MAX_LEN         = lsd_pkg::MAX_LEN_DEF,
  parameter int LOOKAHEAD_LIMIT = lsd_pkg::LOOKAHEAD_DEF,
  parameter int SYNC_LIMIT      = lsd_pkg::SYNC_DEF,
  localparam int IW = $clog2(MAX_LEN)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  lsd_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lsd_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lsd_pkg::out_item_t                out_data,
  output logic                              l_we,
  output logic                              r_we,
  output logic [IW-1:0]                     l_waddr,
  output logic [IW-1:0]                     r_waddr,
  output logic [lsd_pkg::WORD_WIDTH-1:0]    wdata,
  output logic [IW-1:0]                     l_raddr,
  output logic [IW-1:0]                     r_raddr,
  input  logic [lsd_pkg::WORD_WIDTH-1:0]    l_rdata,
  input  logic [lsd_pkg::WORD_WIDTH-1:0]    r_rdata
);

  import lsd_pkg::*;

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = $clog2(LOOKAHEAD_LIMIT + 1);
  localparam int KW = $clog2(SYNC_LIMIT + 1);
  localparam int AW = $clog2(MAX_LEN + LOOKAHEAD_LIMIT + SYNC_LIMIT + 1);

  function automatic out_item_t mk(kind_t kd, logic [WORD_WIDTH-1:0] lw,
                                   logic [WORD_WIDTH-1:0] rw, logic [POS_W-1:0] lp,
                                   logic [POS_W-1:0] rp, logic lst);
    out_item_t r;
    r.kind           = kd;
    r.left_word      = lw;
    r.right_word     = rw;
    r.left_position  = lp;
    r.right_position = rp;
    r.last           = lst;
    return r;
  endfunction

  state_t                state, state_next;
  logic [CW-1:0]         lcount, lcount_next, rcount, rcount_next;
  logic [CW-1:0]         lcur, lcur_next, rcur, rcur_next;
  logic                  side, side_next;
  logic [SW-1:0]         s, s_next, s1, s1_next, run_len, run_len_next;
  logic                  f1, f1_next;
  logic [KW-1:0]         k, k_next;
  logic [WORD_WIDTH-1:0] a_word, a_word_next, b_word, b_word_next;
  out_item_t             res, res_next, out_next;
  logic                  load;

  logic [SW-1:0] depth_eff;
  logic [KW-1:0] syn_eff;
  logic [AW-1:0] base_i, base_j, ii, jj;
  logic          l_in, r_in, off_ok, found, pair_ok, out_free;
  logic          left_win, right_win, run_last;

  assign depth_eff = (32'(cfg.lookahead_depth) > 32'(LOOKAHEAD_LIMIT)) ?
                     SW'(LOOKAHEAD_LIMIT) : SW'(cfg.lookahead_depth);
  assign syn_eff   = (32'(cfg.sync_length) > 32'(SYNC_LIMIT)) ?
                     KW'(SYNC_LIMIT) : KW'(cfg.sync_length);

  // left search shifts the left index by s, right search the right index
  assign base_i = AW'(lcur) + (side ? AW'(0) : AW'(s));
  assign base_j = AW'(rcur) + (side ? AW'(s) : AW'(0));
  assign ii     = base_i + AW'(k);
  assign jj     = base_j + AW'(k);

  assign l_in     = lcur < lcount;
  assign r_in     = rcur < rcount;
  assign off_ok   = (s < depth_eff) &&
                    (side ? (base_j < AW'(rcount)) : (base_i < AW'(lcount)));
  assign found    = off_ok && (k == syn_eff);
  assign pair_ok  = (ii < AW'(lcount)) && (jj < AW'(rcount));
  assign left_win  = f1 && (!found || (s1 < s));
  assign right_win = found && (!f1 || (s < s1));
  assign run_last  = (s + SW'(1)) == run_len;
  assign out_free  = !out_valid || !out_stall;

  assign l_waddr = IW'(lcount);
  assign r_waddr = IW'(rcount);
  assign wdata   = in_data.word;
  assign l_raddr = (state == ST_IDLE) ? IW'(lcur) : IW'(ii);
  assign r_raddr = (state == ST_IDLE) ? IW'(rcur) : IW'(jj);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lcount    <= '0;
      rcount    <= '0;
      lcur      <= '0;
      rcur      <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      lcount <= lcount_next;
      rcount <= rcount_next;
      lcur   <= lcur_next;
      rcur   <= rcur_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    side    <= side_next;
    s       <= s_next;
    s1      <= s1_next;
    f1      <= f1_next;
    k       <= k_next;
    run_len <= run_len_next;
    a_word  <= a_word_next;
    b_word  <= b_word_next;
    res     <= res_next;
    if (load) begin
      out_data <= out_next;
    end
  end

  always_comb begin
    state_next   = state;
    lcount_next  = lcount;
    rcount_next  = rcount;
    lcur_next    = lcur;
    rcur_next    = rcur;
    side_next    = side;
    s_next       = s;
    s1_next      = s1;
    f1_next      = f1;
    k_next       = k;
    run_len_next = run_len;
    a_word_next  = a_word;
    b_word_next  = b_word;
    res_next     = res;
    out_next     = res;
    load         = 1'b0;
    l_we         = 1'b0;
    r_we         = 1'b0;
    in_stall     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          unique case (in_data.opcode)
            OP_CLEAR: begin
              lcount_next = '0;
              rcount_next = '0;
              lcur_next   = '0;
              rcur_next   = '0;
            end
            OP_APPEND_LEFT: begin
              if (lcount < CW'(MAX_LEN)) begin
                l_we        = 1'b1;
                lcount_next = lcount + CW'(1);
              end else begin
                res_next   = mk(K_OVERFLOW, in_data.word, '0, '0, '0, 1'b1);
                state_next = ST_EMIT;
              end
            end
            OP_APPEND_RIGHT: begin
              if (rcount < CW'(MAX_LEN)) begin
                r_we        = 1'b1;
                rcount_next = rcount + CW'(1);
              end else begin
                res_next   = mk(K_OVERFLOW, '0, in_data.word, '0, '0, 1'b1);
                state_next = ST_EMIT;
              end
            end
            OP_STEP: state_next = ST_HEAD;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_HEAD: begin
        a_word_next = l_rdata;
        b_word_next = r_rdata;
        state_next  = ST_EMIT;
        if (l_in && r_in) begin
          if (l_rdata == r_rdata) begin
            res_next  = mk(K_COMMON, l_rdata, r_rdata, POS_W'(lcur), POS_W'(rcur), 1'b1);
            lcur_next = lcur + CW'(1);
            rcur_next = rcur + CW'(1);
          end else begin
            state_next = ST_SRCH_CHK;
            side_next  = 1'b0;
            s_next     = SW'(1);
            k_next     = '0;
          end
        end else if (l_in) begin
          res_next  = mk(K_LEFT, l_rdata, '0, POS_W'(lcur), '0, 1'b1);
          lcur_next = lcur + CW'(1);
        end else if (r_in) begin
          res_next  = mk(K_RIGHT, '0, r_rdata, '0, POS_W'(rcur), 1'b1);
          rcur_next = rcur + CW'(1);
        end else begin
          res_next = mk(K_FINISHED, '0, '0, '0, '0, 1'b1);
        end
      end
      ST_SRCH_CHK: begin
        if (!off_ok || (k == syn_eff)) begin
          // this side's search is over, found or exhausted
          if (!side) begin
            f1_next   = found;
            s1_next   = s;
            side_next = 1'b1;
            s_next    = SW'(1);
            k_next    = '0;
          end else if (left_win) begin
            side_next    = 1'b0;
            s_next       = '0;
            k_next       = '0;
            run_len_next = s1;
            state_next   = ST_RUN_RD;
          end else if (right_win) begin
            side_next    = 1'b1;
            s_next       = '0;
            k_next       = '0;
            run_len_next = s;
            state_next   = ST_RUN_RD;
          end else begin
            res_next   = mk(K_DIFF, a_word, b_word, POS_W'(lcur), POS_W'(rcur), 1'b1);
            lcur_next  = lcur + CW'(1);
            rcur_next  = rcur + CW'(1);
            state_next = ST_EMIT;
          end
        end else if (pair_ok) begin
          state_next = ST_SRCH_CMP;
        end else begin
          s_next = s + SW'(1);
          k_next = '0;
        end
      end
      ST_SRCH_CMP: begin
        if (l_rdata == r_rdata) begin
          k_next = k + KW'(1);
        end else begin
          s_next = s + SW'(1);
          k_next = '0;
        end
        state_next = ST_SRCH_CHK;
      end
      ST_RUN_RD: state_next = ST_RUN_EMIT;
      ST_RUN_EMIT: begin
        // read address holds here, so the ram output stays put while stalled
        if (out_free) begin
          load     = 1'b1;
          out_next = side ? mk(K_RIGHT, '0, r_rdata, '0, POS_W'(jj), run_last)
                          : mk(K_LEFT, l_rdata, '0, POS_W'(ii), '0, run_last);
          if (run_last) begin
            if (side) begin
              rcur_next = rcur + CW'(run_len);
            end else begin
              lcur_next = lcur + CW'(run_len);
            end
            state_next = ST_IDLE;
          end else begin
            s_next     = s + SW'(1);
            state_next = ST_RUN_RD;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

`ifndef ASSERT_OFF
  a_lcur_bound: assert property (@(posedge clk) disable iff (rst) lcur <= lcount)
    else $error("left cursor beyond left count");
  a_rcur_bound: assert property (@(posedge clk) disable iff (rst) rcur <= rcount)
    else $error("right cursor beyond right count");
  a_cmp_after_chk: assert property (@(posedge clk) disable iff (rst)
    state == ST_SRCH_CMP |-> $past(state) == ST_SRCH_CHK)
    else $error("search compare without a read issued");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/lookahead_sequence_diff_unit.sv
// Lookahead sequence diff unit. Holds a left and a right word sequence (up to MAX_LEN
// words each, one append per request) and diffs them greedily, one decision per step
// request. On a mismatch the step searches both sides in turn through the two word
// memories, issuing one read and then one compare per word pair, and then emits each
// skipped word after its own read. The single read port of each memory is why the
// reads and compares alternate.
// depends on lsd_pkg, lsd_ram, lsd_ctrl
`default_nettype none

module lookahead_sequence_diff_unit #(
  parameter int MAX_LEN         = lsd_pkg::MAX_LEN_DEF,
  parameter int LOOKAHEAD_LIMIT = lsd_pkg::LOOKAHEAD_DEF,
  parameter int SYNC_LIMIT      = lsd_pkg::SYNC_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lsd_pkg::in_item_t                in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lsd_pkg::out_item_t               out_data,
  input  logic                             cfg_we,
  input  lsd_pkg::reg_idx_t                cfg_index,
  input  logic [lsd_pkg::DEPTH_W-1:0]      cfg_data
);

  import lsd_pkg::*;

  localparam int IW = $clog2(MAX_LEN);

  cfg_t                  cfg;
  logic                  l_we, r_we;
  logic [IW-1:0]         l_waddr, r_waddr, l_raddr, r_raddr;
  logic [WORD_WIDTH-1:0] wdata, l_rdata, r_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lookahead_depth <= DEPTH_RESET;
      cfg.sync_length     <= SYNC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOOKAHEAD_DEPTH: cfg.lookahead_depth <= cfg_data;
        REG_SYNC_LENGTH:     cfg.sync_length     <= cfg_data[SYNC_W-1:0];
        default:             cfg                 <= cfg;
      endcase
    end
  end

  lsd_ram #(.WIDTH(WORD_WIDTH), .DEPTH(MAX_LEN)) u_left_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  lsd_ram #(.WIDTH(WORD_WIDTH), .DEPTH(MAX_LEN)) u_right_ram (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (wdata),
    .raddr (r_raddr),
    .rdata (r_rdata)
  );

  lsd_ctrl #(
    .MAX_LEN         (MAX_LEN),
    .LOOKAHEAD_LIMIT (LOOKAHEAD_LIMIT),
    .SYNC_LIMIT      (SYNC_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .l_we      (l_we),
    .r_we      (r_we),
    .l_waddr   (l_waddr),
    .r_waddr   (r_waddr),
    .wdata     (wdata),
    .l_raddr   (l_raddr),
    .r_raddr   (r_raddr),
    .l_rdata   (l_rdata),
    .r_rdata   (r_rdata)
  );

endmodule

`default_nettype wire

FILE: verif/tb.sv
// tb: self-checking bench for lookahead_sequence_diff_unit, with directed and random
// append/clear/step requests under random idling on both channels
// depends on lsd_pkg and the rtl of lookahead_sequence_diff_unit
`default_nettype none

module tb;
  import lsd_pkg::*;

  localparam int MAXL = 1024;
  localparam int WDOG_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  reg_idx_t cfg_index = REG_LOOKAHEAD_DEPTH;
  logic [DEPTH_W-1:0] cfg_data = '0;

  lookahead_sequence_diff_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // diff model state
  logic [WORD_WIDTH-1:0] left_words [MAXL];
  logic [WORD_WIDTH-1:0] right_words [MAXL];
  int left_len, right_len, left_pos, right_pos;
  int depth_cfg = 32, sync_cfg = 3;

  out_item_t expected_q [$];
  int n_requests, n_results, n_errors, n_cfg_writes, n_steps;
  bit send_busy, recv_busy;
  int recv_hold;
  int idle_cycles;

  function automatic out_item_t mk(kind_t k, logic [31:0] lw, logic [31:0] rw,
                                   int lp, int rp);
    out_item_t r;
    r = '0;
    r.kind = k;
    r.left_word = lw;
    r.right_word = rw;
    r.left_position = lp[POS_W-1:0];
    r.right_position = rp[POS_W-1:0];
    return r;
  endfunction

  function automatic bit run_equal(int i, int j, int n);
    while (n > 0 && i < left_len && j < right_len && left_words[i] == right_words[j]) begin
      n--; i++; j++;
    end
    return n == 0;
  endfunction

  task automatic predict_diff(in_item_t req);
    out_item_t res [$];
    int d, s, s1, s2;
    bit f1, f2;
    res = {};
    case (req.opcode)
      OP_CLEAR: begin
        left_len = 0; right_len = 0; left_pos = 0; right_pos = 0;
      end
      OP_APPEND_LEFT: begin
        if (left_len < MAXL) left_words[left_len++] = req.word;
        else res.push_back(mk(K_OVERFLOW, req.word, 0, 0, 0));
      end
      OP_APPEND_RIGHT: begin
        if (right_len < MAXL) right_words[right_len++] = req.word;
        else res.push_back(mk(K_OVERFLOW, 0, req.word, 0, 0));
      end
      default: begin
        n_steps++;
        if (left_pos < left_len && right_pos < right_len) begin
          if (left_words[left_pos] == right_words[right_pos]) begin
            res.push_back(mk(K_COMMON, left_words[left_pos], right_words[right_pos],
                             left_pos, right_pos));
            left_pos++; right_pos++;
          end else begin
            d = depth_cfg > 32 ? 32 : depth_cfg;
            s = sync_cfg > 8 ? 8 : sync_cfg;
            f1 = 0; f2 = 0;
            for (s1 = 1; left_pos + s1 < left_len && s1 < d; s1++)
              if (run_equal(left_pos + s1, right_pos, s)) begin f1 = 1; break; end
            for (s2 = 1; right_pos + s2 < right_len && s2 < d; s2++)
              if (run_equal(left_pos, right_pos + s2, s)) begin f2 = 1; break; end
            if (f1 && (!f2 || s1 < s2)) begin
              for (int k = 0; k < s1; k++)
                res.push_back(mk(K_LEFT, left_words[left_pos + k], 0, left_pos + k, 0));
              left_pos += s1;
            end else if (f2 && (!f1 || s2 < s1)) begin
              for (int k = 0; k < s2; k++)
                res.push_back(mk(K_RIGHT, 0, right_words[right_pos + k], 0, right_pos + k));
              right_pos += s2;
            end else begin
              res.push_back(mk(K_DIFF, left_words[left_pos], right_words[right_pos],
                               left_pos, right_pos));
              left_pos++; right_pos++;
            end
          end
        end else if (left_pos < left_len) begin
          res.push_back(mk(K_LEFT, left_words[left_pos], 0, left_pos, 0));
          left_pos++;
        end else if (right_pos < right_len) begin
          res.push_back(mk(K_RIGHT, 0, right_words[right_pos], 0, right_pos));
          right_pos++;
        end else begin
          res.push_back(mk(K_FINISHED, 0, 0, 0, 0));
        end
      end
    endcase
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
    foreach (res[i]) expected_q.push_back(res[i]);
  endtask

  // one request: random gap, then hold until accepted
  task automatic send(op_t op, logic [31:0] w);
    in_item_t req;
    int gap;
    req.opcode = op;
    req.word = w;
    gap = send_busy ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    n_requests++;
    predict_diff(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // appends and clears leave no result, give the block time to settle
    repeat (40) @(posedge clk);
  endtask

  task automatic set_cfg(reg_idx_t idx, int v);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[DEPTH_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_LOOKAHEAD_DEPTH) depth_cfg = v & 6'h3f;
    else sync_cfg = v & 4'hf;
    n_cfg_writes++;
  endtask

  task automatic load_pair(logic [31:0] l [$], logic [31:0] r [$]);
    send(OP_CLEAR, $urandom);
    foreach (l[i]) send(OP_APPEND_LEFT, l[i]);
    foreach (r[i]) send(OP_APPEND_RIGHT, r[i]);
  endtask

  task automatic steps(int n);
    repeat (n) send(OP_STEP, $urandom);
  endtask

  // result check and receiver stall
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      n_results++;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("unexpected result %p", out_data);
      end else begin
        out_item_t e;
        e = expected_q.pop_front();
        if (e.kind !== out_data.kind || e.left_word !== out_data.left_word ||
            e.right_word !== out_data.right_word ||
            e.left_position !== out_data.left_position ||
            e.right_position !== out_data.right_position || e.last !== out_data.last) begin
          n_errors++;
          if (n_errors <= 10) $display("mismatch: expected %p got %p", e, out_data);
        end
      end
      recv_hold = recv_busy ? 0 : $urandom_range(0, 12);
    end else if (recv_hold > 0) begin
      recv_hold--;
    end
    out_stall <= (recv_hold != 0);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_empty_and_common();
    logic [31:0] l [$];
    logic [31:0] r [$];
    send(OP_CLEAR, 0);
    steps(1);
    l = '{32'h0, 32'hffffffff, 32'h5};
    r = '{32'h0, 32'hffffffff, 32'h6};
    load_pair(l, r);
    steps(4);
  endtask

  task automatic test_skips_and_tails();
    logic [31:0] l [$];
    logic [31:0] r [$];
    // extra word on the left, then extra on the right, then a differing pair and a tail
    l = '{1, 9, 2, 3, 4, 5, 6, 7};
    r = '{1, 2, 3, 4, 8, 5, 6, 7, 11, 12};
    load_pair(l, r);
    steps(5);
    send(OP_APPEND_LEFT, 32'hdead_beef); // append in the middle of a diff
    steps(8);
  endtask

  task automatic test_limits();
    logic [31:0] l [$];
    logic [31:0] r [$];
    l = '{1, 2, 3, 4, 5};
    r = '{9, 1, 2, 3, 4, 5};
    set_cfg(REG_LOOKAHEAD_DEPTH, 0);
    load_pair(l, r); steps(3);
    set_cfg(REG_LOOKAHEAD_DEPTH, 1);
    set_cfg(REG_SYNC_LENGTH, 0);
    load_pair(l, r); steps(3);
    set_cfg(REG_LOOKAHEAD_DEPTH, 63);
    load_pair(l, r); steps(2);
    set_cfg(REG_SYNC_LENGTH, 15);
    load_pair(l, r); steps(3);
    set_cfg(REG_SYNC_LENGTH, 8);
    set_cfg(REG_LOOKAHEAD_DEPTH, 32);
  endtask

  task automatic test_random(int n_items);
    int stop_at, len_l, len_r, alpha;
    logic [31:0] l [$];
    logic [31:0] r [$];
    stop_at = n_requests + n_items;
    while (n_requests < stop_at) begin
      if ($urandom_range(0, 7) == 0) begin
        set_cfg(REG_LOOKAHEAD_DEPTH, $urandom_range(0, 63));
        set_cfg(REG_SYNC_LENGTH, $urandom_range(0, 15));
      end
      send_busy = ($urandom_range(0, 3) == 0);
      recv_busy = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: random opcodes and words
        repeat ($urandom_range(1, 6)) send(op_t'($urandom_range(0, 3)), $urandom);
      end else begin
        alpha = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4);
        len_l = $urandom_range(0, 14);
        l = {};
        r = {};
        repeat (len_l) l.push_back(alpha == 0 ? $urandom : $urandom_range(0, alpha));
        foreach (l[i]) begin
          case ($urandom_range(0, 5))
            0: ;
            1: begin r.push_back(l[i]); r.push_back($urandom_range(0, 9)); end
            2: r.push_back($urandom);
            default: r.push_back(l[i]);
          endcase
        end
        len_r = r.size();
        load_pair(l, r);
        steps($urandom_range(0, 3) == 0 ? $urandom_range(1, 4) : len_l + len_r + 1);
        if ($urandom_range(0, 3) == 0) begin
          send(OP_APPEND_RIGHT, $urandom_range(0, 4));
          steps(2);
        end
      end
    end
    send_busy = 0;
    recv_busy = 0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_and_common();
    test_skips_and_tails();
    test_limits();
    set_cfg(REG_LOOKAHEAD_DEPTH, 32);
    set_cfg(REG_SYNC_LENGTH, 3);
    test_random(70);
    test_random(60);
    drain();
    $display("%0d requests, %0d diff steps, %0d results checked, %0d register writes",
             n_requests, n_steps, n_results, n_cfg_writes);
    $display("covered common/skip/differing/tail/finished paths, %0d errors",
             n_errors);
    if (n_errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

`default_nettype wire
